// ===== rtl/core/indexed_min_heap_with_position_map_assert.svh =====
// Assertion macros for the indexed min-heap block.
`ifndef INDEXED_MIN_HEAP_WITH_POSITION_MAP_ASSERT_SVH
`define INDEXED_MIN_HEAP_WITH_POSITION_MAP_ASSERT_SVH

`ifndef SYNTHESIS
// plain property, checked on every edge outside reset
`define IMH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// implication from an antecedent to a consequent on the same edge
`define IMH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// consequent checked on the edge after the antecedent
`define IMH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define IMH_ASSERT(lbl, prop, msg)
`define IMH_ASSERT_IMP(lbl, ante, cons, msg)
`define IMH_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/core/imh_pkg.sv =====
// Types, constants and helpers shared by the indexed min-heap block.
`timescale 1ns / 1ps
`default_nettype none
package imh_pkg;

  localparam int MAX_ENTRIES = 1024;
  localparam int MAX_WIDTH   = 256;
  localparam int MAX_HEIGHT  = 256;
  localparam int MAP_DEPTH   = MAX_WIDTH * MAX_HEIGHT;
  localparam int MAP_AW      = $clog2(MAP_DEPTH);
  localparam int SLOT_W      = $clog2(MAX_ENTRIES + 1);
  localparam int HEAP_AW     = $clog2(MAX_ENTRIES);
  localparam int CFG_W       = 9;

  // action codes
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_POP    = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;
  localparam logic [1:0] ACT_QUERY  = 2'd3;

  // status codes
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_EMPTY  = 3'd1;
  localparam logic [2:0] ST_FULL   = 3'd2;
  localparam logic [2:0] ST_ABSENT = 3'd3;
  localparam logic [2:0] ST_DUP    = 3'd4;
  localparam logic [2:0] ST_RANGE  = 3'd5;

  // configuration register indexes
  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef struct packed {
    logic [1:0]         action;
    logic [7:0]         coord_x;
    logic [7:0]         coord_y;
    logic signed [31:0] priority_req;
  } in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [7:0]         out_x;
    logic [7:0]         out_y;
    logic signed [31:0] out_priority;
    logic               present;
    logic [SLOT_W-1:0]  count;
  } out_t;

  // one heap entry as stored in the slot memory
  typedef struct packed {
    logic [7:0]         x;
    logic [7:0]         y;
    logic signed [31:0] pri;
  } ent_t;

  // map address of a pixel: y * width + x (width already clamped)
  function automatic logic [MAP_AW-1:0] map_index(input logic [7:0] x, input logic [7:0] y,
                                                  input logic [CFG_W-1:0] w);
    logic [MAP_AW:0] s;
    s = (MAP_AW + 1)'(y) * (MAP_AW + 1)'(w) + (MAP_AW + 1)'(x);
    return s[MAP_AW-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/indexed_min_heap_with_position_map.sv =====
// Indexed binary min-heap of pixel entries with a pixel-to-slot position map.
// Pops of an empty heap and out-of-range requests are rejected at decode; queries and other
// rejects are answered after the map and slot reads; insert, pop and remove sift level by level.
// One item at a time; the bound is the single read port of the slot memory per level.
// Reset: synchronous; afterwards the map memory is cleared one entry per cycle
// with input ready low; configuration writes are taken throughout.
`timescale 1ns / 1ps
`default_nettype none
`include "indexed_min_heap_with_position_map_assert.svh"
module indexed_min_heap_with_position_map
  import imh_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire in_t              in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_t                  out_data,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_POP_RD, S_MAP_WAIT, S_CHECK, S_LAST_RD,
    S_RM_W1, S_RM_W2, S_DN_START, S_DN_RL, S_DN_RR, S_DN_CMP, S_UP_START,
    S_UP_RD, S_MW1, S_MW2, S_FINAL, S_DONE
  } state_t;

  state_t             state;
  logic [SLOT_W-1:0]  cnt;
  logic [CFG_W-1:0]   width_reg;
  logic [CFG_W-1:0]   height_reg;
  logic [MAP_AW-1:0]  clr_addr;
  in_t                req;
  logic [MAP_AW-1:0]  idx;
  logic [SLOT_W-1:0]  s;
  logic [MAP_AW-1:0]  rm_idx;
  ent_t               mv;
  logic [MAP_AW-1:0]  mv_idx;
  ent_t               c;
  logic [SLOT_W-1:0]  cslot;
  logic [MAP_AW-1:0]  sh_idx;
  logic [SLOT_W-1:0]  hole;
  logic               moved;
  logic               dir_up;
  out_t               res;

  // memory ports
  logic               heap_we;
  logic [HEAP_AW-1:0] heap_waddr;
  ent_t               heap_wdata;
  logic [HEAP_AW-1:0] heap_raddr;
  ent_t               heap_rdata;
  logic               map_we;
  logic [MAP_AW-1:0]  map_waddr;
  logic [SLOT_W-1:0]  map_wdata;
  logic [MAP_AW-1:0]  map_raddr;
  logic [SLOT_W-1:0]  map_rdata;

  // clamped image size
  logic [CFG_W-1:0] eff_w;
  logic [CFG_W-1:0] eff_h;
  assign eff_w = (width_reg > CFG_W'(MAX_WIDTH)) ? CFG_W'(MAX_WIDTH) : width_reg;
  assign eff_h = (height_reg > CFG_W'(MAX_HEIGHT)) ? CFG_W'(MAX_HEIGHT) : height_reg;

  // slot arithmetic
  logic [SLOT_W:0]   lchild;
  logic [SLOT_W-1:0] parent;
  logic              found;
  logic              in_range;
  assign lchild   = {hole, 1'b0};
  assign parent   = hole >> 1;
  assign found    = (s != '0) && (s <= cnt) &&
                    (heap_rdata.x == req.coord_x) && (heap_rdata.y == req.coord_y);
  assign in_range = ({1'b0, req.coord_x} < eff_w) && ({1'b0, req.coord_y} < eff_h);

  // shift decisions
  logic dn_shift;
  logic up_shift;
  assign dn_shift = $signed(mv.pri) > $signed(c.pri);
  assign up_shift = $signed(heap_rdata.pri) > $signed(mv.pri);

  assign in_ready = (state == S_IDLE);

  imh_ram #(.WIDTH($bits(ent_t)), .DEPTH(MAX_ENTRIES)) u_heap_ram (
    .clk   (clk),
    .we    (heap_we),
    .waddr (heap_waddr),
    .wdata (heap_wdata),
    .raddr (heap_raddr),
    .rdata (heap_rdata)
  );

  imh_ram #(.WIDTH(SLOT_W), .DEPTH(MAP_DEPTH)) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  // memory port control
  always_comb begin
    heap_we    = 1'b0;
    heap_waddr = HEAP_AW'(hole - SLOT_W'(1));
    heap_wdata = mv;
    heap_raddr = HEAP_AW'(cnt - SLOT_W'(1));
    map_we     = 1'b0;
    map_waddr  = mv_idx;
    map_wdata  = s;
    map_raddr  = idx;
    case (state)
      S_CLEAR: begin
        map_we    = 1'b1;
        map_waddr = clr_addr;
        map_wdata = '0;
      end
      S_DECODE: begin
        heap_raddr = '0;
      end
      S_MAP_WAIT: begin
        heap_raddr = HEAP_AW'(map_rdata - SLOT_W'(1));
      end
      S_CHECK: begin
        if (req.action == ACT_INSERT && !found && cnt < SLOT_W'(MAX_ENTRIES)) begin
          map_we    = 1'b1;
          map_waddr = idx;
          map_wdata = cnt + SLOT_W'(1);
        end
      end
      S_RM_W1: begin
        map_we = 1'b1;
      end
      S_RM_W2: begin
        map_we    = 1'b1;
        map_waddr = rm_idx;
        map_wdata = '0;
      end
      S_DN_START: begin
        heap_raddr = HEAP_AW'(lchild - (SLOT_W + 1)'(1));
      end
      S_DN_RL: begin
        heap_raddr = HEAP_AW'(lchild);
      end
      S_DN_CMP: begin
        heap_we    = dn_shift;
        heap_wdata = c;
      end
      S_UP_START: begin
        heap_raddr = HEAP_AW'(parent - SLOT_W'(1));
      end
      S_UP_RD: begin
        heap_we    = up_shift;
        heap_wdata = heap_rdata;
      end
      S_MW1: begin
        map_we    = 1'b1;
        map_waddr = sh_idx;
        map_wdata = hole;
      end
      S_MW2: begin
        map_we    = 1'b1;
        map_waddr = mv_idx;
        map_wdata = cslot;
      end
      S_FINAL: begin
        heap_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= CFG_W'(256);
      height_reg <= CFG_W'(256);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WIDTH:  width_reg  <= cfg_data;
        CFG_HEIGHT: height_reg <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      cnt       <= '0;
      clr_addr  <= '0;
      out_valid <= 1'b0;
      moved     <= 1'b0;
      dir_up    <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + MAP_AW'(1);
          if (clr_addr == MAP_AW'(MAP_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            req   <= in_data;
            idx   <= map_index(in_data.coord_x, in_data.coord_y, eff_w);
            res   <= '0;
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          if (req.action == ACT_POP) begin
            if (cnt == '0) begin
              res.status <= ST_EMPTY;
              state      <= S_DONE;
            end else begin
              state <= S_POP_RD;
            end
          end else if (!in_range) begin
            res.status <= ST_RANGE;
            state      <= S_DONE;
          end else begin
            state <= S_MAP_WAIT;
          end
        end
        S_POP_RD: begin
          res.out_x        <= heap_rdata.x;
          res.out_y        <= heap_rdata.y;
          res.out_priority <= heap_rdata.pri;
          rm_idx           <= map_index(heap_rdata.x, heap_rdata.y, eff_w);
          s                <= SLOT_W'(1);
          state            <= S_LAST_RD;
        end
        S_MAP_WAIT: begin
          s     <= map_rdata;
          state <= S_CHECK;
        end
        S_CHECK: begin
          case (req.action)
            ACT_QUERY: begin
              res.present <= found;
              state       <= S_DONE;
            end
            ACT_INSERT: begin
              if (found) begin
                res.status <= ST_DUP;
                state      <= S_DONE;
              end else if (cnt >= SLOT_W'(MAX_ENTRIES)) begin
                res.status <= ST_FULL;
                state      <= S_DONE;
              end else begin
                cnt    <= cnt + SLOT_W'(1);
                hole   <= cnt + SLOT_W'(1);
                mv     <= '{x: req.coord_x, y: req.coord_y, pri: req.priority_req};
                mv_idx <= idx;
                state  <= S_UP_START;
              end
            end
            default: begin
              if (!found) begin
                res.status <= ST_ABSENT;
                state      <= S_DONE;
              end else begin
                rm_idx <= idx;
                state  <= S_LAST_RD;
              end
            end
          endcase
        end
        S_LAST_RD: begin
          mv     <= heap_rdata;
          mv_idx <= map_index(heap_rdata.x, heap_rdata.y, eff_w);
          cnt    <= cnt - SLOT_W'(1);
          state  <= S_RM_W1;
        end
        S_RM_W1: begin
          state <= S_RM_W2;
        end
        S_RM_W2: begin
          if (s > cnt) begin
            state <= S_DONE;
          end else begin
            hole  <= s;
            moved <= 1'b0;
            state <= S_DN_START;
          end
        end
        // sift down: pick the smaller child, shift it up into the hole
        S_DN_START: begin
          if (lchild > (SLOT_W + 1)'(cnt)) begin
            state <= moved ? S_FINAL : S_UP_START;
          end else begin
            state <= S_DN_RL;
          end
        end
        S_DN_RL: begin
          c     <= heap_rdata;
          cslot <= lchild[SLOT_W-1:0];
          state <= (lchild < (SLOT_W + 1)'(cnt)) ? S_DN_RR : S_DN_CMP;
        end
        S_DN_RR: begin
          if ($signed(c.pri) > $signed(heap_rdata.pri)) begin
            c     <= heap_rdata;
            cslot <= lchild[SLOT_W-1:0] + SLOT_W'(1);
          end
          state <= S_DN_CMP;
        end
        S_DN_CMP: begin
          if (dn_shift) begin
            sh_idx <= map_index(c.x, c.y, eff_w);
            dir_up <= 1'b0;
            state  <= S_MW1;
          end else begin
            // nothing moved down: the entry may still have to rise
            state <= moved ? S_FINAL : S_UP_START;
          end
        end
        // sift up: shift a larger parent down into the hole
        S_UP_START: begin
          state <= (hole == SLOT_W'(1)) ? S_FINAL : S_UP_RD;
        end
        S_UP_RD: begin
          if (up_shift) begin
            sh_idx <= map_index(heap_rdata.x, heap_rdata.y, eff_w);
            cslot  <= parent;
            dir_up <= 1'b1;
            state  <= S_MW1;
          end else begin
            state <= S_FINAL;
          end
        end
        S_MW1: begin
          state <= S_MW2;
        end
        S_MW2: begin
          hole  <= cslot;
          moved <= 1'b1;
          state <= dir_up ? S_UP_START : S_DN_START;
        end
        S_FINAL: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_data  <= '{status: res.status, out_x: res.out_x, out_y: res.out_y,
                           out_priority: res.out_priority, present: res.present,
                           count: cnt};
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  `IMH_ASSERT_IMP(a_heap_wr_in_use, heap_we, {1'b0, heap_waddr} < cnt, "heap write beyond count")
  `IMH_ASSERT_IMP(a_cnt_step, !$past(rst) && cnt != $past(cnt), cnt == $past(cnt) + SLOT_W'(1) || cnt + SLOT_W'(1) == $past(cnt), "count moved by more than one")
  `IMH_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "second beat taken while busy")
  `IMH_ASSERT(a_cnt_bound, cnt <= SLOT_W'(MAX_ENTRIES), "count above capacity")

endmodule
`default_nettype wire

// ===== rtl/core/imh_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module imh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== test/indexed_min_heap_with_position_map_tb.sv =====
// Self-checking testbench for the indexed min-heap with position map.
`timescale 1ns / 1ps
module indexed_min_heap_with_position_map_tb;
  import imh_pkg::*;

  // Scoreboard: own heap and pixel map, predicts one result per beat
  class heap_scoreboard;
    ent_t              slots[MAX_ENTRIES + 1];
    logic [SLOT_W-1:0] pixel_slot[MAP_DEPTH];
    int                fill;
    int                width_reg;
    int                height_reg;
    out_t              awaited[$];
    int                errors;

    function void clear();
      foreach (slots[i]) slots[i] = '0;
      foreach (pixel_slot[i]) pixel_slot[i] = '0;
      fill = 0;
      width_reg = 256;
      height_reg = 256;
      errors = 0;
    endfunction

    function int eff_width();
      return (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
    endfunction

    function int eff_height();
      return (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
    endfunction

    function int pixel_addr(logic [7:0] x, logic [7:0] y);
      int a;
      a = int'(y) * eff_width() + int'(x);
      return (a < MAP_DEPTH) ? a : 0;
    endfunction

    // strict: slot a ranks behind slot b
    function bit heavier(int a, int b);
      return slots[a].pri > slots[b].pri;
    endfunction

    function void swap_slots(int a, int b);
      ent_t t;
      t = slots[a];
      slots[a] = slots[b];
      slots[b] = t;
      pixel_slot[pixel_addr(slots[a].x, slots[a].y)] = SLOT_W'(a);
      pixel_slot[pixel_addr(slots[b].x, slots[b].y)] = SLOT_W'(b);
    endfunction

    function void bubble_up(int k);
      while (k > 1 && heavier(k / 2, k)) begin
        swap_slots(k, k / 2);
        k = k / 2;
      end
    endfunction

    function void bubble_down(int k);
      int j;
      while (2 * k <= fill) begin
        j = 2 * k;
        if (j < fill && heavier(j, j + 1)) j++;
        if (!heavier(k, j)) break;
        swap_slots(k, j);
        k = j;
      end
    endfunction

    function int locate(logic [7:0] x, logic [7:0] y);
      int s;
      s = int'(pixel_slot[pixel_addr(x, y)]);
      if (s == 0 || s > fill) return 0;
      if (slots[s].x != x || slots[s].y != y) return 0;
      return s;
    endfunction

    // accepted input beat: update state, queue the expected result
    function void note_input(in_t d);
      out_t r;
      ent_t top;
      int   s;
      bit   in_range;
      r = '0;
      r.status = ST_OK;
      in_range = (int'(d.coord_x) < eff_width()) && (int'(d.coord_y) < eff_height());
      if (d.action == ACT_POP) begin
        if (fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          top = slots[1];
          r.out_x = top.x;
          r.out_y = top.y;
          r.out_priority = top.pri;
          swap_slots(1, fill);
          fill--;
          pixel_slot[pixel_addr(top.x, top.y)] = '0;
          bubble_down(1);
        end
      end else if (!in_range) begin
        r.status = ST_RANGE;
      end else if (d.action == ACT_INSERT) begin
        if (locate(d.coord_x, d.coord_y) != 0) begin
          r.status = ST_DUP;
        end else if (fill >= MAX_ENTRIES) begin
          r.status = ST_FULL;
        end else begin
          fill++;
          slots[fill].x = d.coord_x;
          slots[fill].y = d.coord_y;
          slots[fill].pri = d.priority_req;
          pixel_slot[pixel_addr(d.coord_x, d.coord_y)] = SLOT_W'(fill);
          bubble_up(fill);
        end
      end else if (d.action == ACT_REMOVE) begin
        s = locate(d.coord_x, d.coord_y);
        if (s == 0) begin
          r.status = ST_ABSENT;
        end else begin
          swap_slots(s, fill);
          fill--;
          pixel_slot[pixel_addr(d.coord_x, d.coord_y)] = '0;
          if (s <= fill) begin
            bubble_down(s);
            bubble_up(s);
          end
        end
      end else begin
        r.present = (locate(d.coord_x, d.coord_y) != 0);
      end
      r.count = SLOT_W'(fill);
      awaited.push_back(r);
    endfunction

    // accepted result beat: compare with the oldest expectation
    function void check_result(out_t got);
      out_t e;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      e = awaited.pop_front();
      if (got.status != e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, got.status);
        errors++;
      end
      if (got.out_x != e.out_x) begin
        $display("%0t: out_x expected %0d actual %0d", $time, e.out_x, got.out_x);
        errors++;
      end
      if (got.out_y != e.out_y) begin
        $display("%0t: out_y expected %0d actual %0d", $time, e.out_y, got.out_y);
        errors++;
      end
      if (got.out_priority != e.out_priority) begin
        $display("%0t: out_priority expected %0d actual %0d", $time, e.out_priority,
                 got.out_priority);
        errors++;
      end
      if (got.present != e.present) begin
        $display("%0t: present expected %0d actual %0d", $time, e.present, got.present);
        errors++;
      end
      if (got.count != e.count) begin
        $display("%0t: count expected %0d actual %0d", $time, e.count, got.count);
        errors++;
      end
    endfunction
  endclass

  localparam int WATCHDOG_LIMIT = 200000;
  localparam int SETTLE_CYCLES  = 120;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  in_t              in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_t             out_data;
  logic             cfg_we = 1'b0;
  logic             cfg_index = 1'b0;
  logic [CFG_W-1:0] cfg_data = '0;

  heap_scoreboard sb;
  int  send_idle_pct;
  int  recv_idle_pct;
  bit  hold_off_req;

  indexed_min_heap_with_position_map uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // result side: check beats, stall at random, long hold-off on request
  initial begin
    int held;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) sb.check_result(out_data);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        for (held = 0; held < 400; held++) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog on cycles with no beat on either channel
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("[indexed_min_heap_with_position_map] ERROR");
        $finish;
      end
    end
  end

  // offer one beat and hold it until accepted, then maybe idle
  task automatic send_beat(in_t d);
    int gap;
    in_valid <= 1'b1;
    in_data  <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(d);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_op(logic [1:0] act, int x, int y, int pri);
    in_t d;
    d.action = act;
    d.coord_x = 8'(x);
    d.coord_y = 8'(y);
    d.priority_req = pri;
    send_beat(d);
  endtask

  // drain all expected results, let the block settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_W'(val);
    @(posedge clk);
    if (idx == CFG_WIDTH) sb.width_reg = val;
    else sb.height_reg = val;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // random beat; weights in percent for insert, pop, remove (rest query)
  task automatic send_random(int w_ins, int w_pop, int w_rem, int span);
    in_t d;
    int  r;
    r = $urandom_range(99);
    if (r < w_ins) d.action = ACT_INSERT;
    else if (r < w_ins + w_pop) d.action = ACT_POP;
    else if (r < w_ins + w_pop + w_rem) d.action = ACT_REMOVE;
    else d.action = ACT_QUERY;
    d.coord_x = 8'($urandom_range(span - 1));
    d.coord_y = 8'($urandom_range(span - 1));
    d.priority_req = ($urandom_range(3) == 0) ? $urandom_range(7) - 4 : $urandom;
    send_beat(d);
  endtask

  initial begin
    int i;
    sb = new();
    sb.clear();
    send_idle_pct = 20;
    recv_idle_pct = 77;
    hold_off_req = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: empty cases, priority extremes, duplicates, ties
    send_op(ACT_POP, 0, 0, 0);
    send_op(ACT_REMOVE, 5, 5, 0);
    send_op(ACT_QUERY, 5, 5, 0);
    send_op(ACT_INSERT, 0, 0, 32'h8000_0000);
    send_op(ACT_INSERT, 255, 255, 32'h7fff_ffff);
    send_op(ACT_INSERT, 0, 0, 7);
    send_op(ACT_INSERT, 5, 5, -1);
    send_op(ACT_INSERT, 6, 5, -1);
    send_op(ACT_QUERY, 255, 255, 0);
    send_op(ACT_REMOVE, 255, 255, 0);
    send_op(ACT_QUERY, 255, 255, 0);
    send_op(ACT_POP, 200, 100, 0);
    send_op(ACT_POP, 0, 0, 0);
    send_op(ACT_POP, 0, 0, 0);
    send_op(ACT_POP, 0, 0, 0);
    wait_idle();

    // small image: out-of-range coordinates
    write_cfg(CFG_WIDTH, 16);
    write_cfg(CFG_HEIGHT, 16);
    send_op(ACT_INSERT, 16, 0, 1);
    send_op(ACT_QUERY, 0, 16, 0);
    send_op(ACT_REMOVE, 200, 3, 0);
    send_op(ACT_INSERT, 15, 15, 3);
    for (i = 0; i < 50; i++) send_random(40, 25, 20, 20);
    wait_idle();

    // wide registers clamp; fill the heap past full, with a long stall
    send_idle_pct = 77;
    recv_idle_pct = 20;
    write_cfg(CFG_WIDTH, 511);
    write_cfg(CFG_HEIGHT, 511);
    for (i = 0; i < 1150; i++) begin
      if (i == 200) hold_off_req = 1'b1;
      send_random(95, 0, 2, 256);
    end
    wait_idle();

    // narrow map with entries queued, then zero size, then back to full
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_cfg(CFG_WIDTH, 1);
    write_cfg(CFG_HEIGHT, 1);
    for (i = 0; i < 60; i++) send_random(20, 60, 10, 2);
    wait_idle();
    write_cfg(CFG_WIDTH, 0);
    write_cfg(CFG_HEIGHT, 0);
    for (i = 0; i < 40; i++) send_random(40, 30, 15, 256);
    wait_idle();
    write_cfg(CFG_WIDTH, 256);
    write_cfg(CFG_HEIGHT, 256);
    for (i = 0; i < 100; i++) send_random(30, 40, 15, 256);
    wait_idle();

    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("[indexed_min_heap_with_position_map] OK");
    end else begin
      $display("[indexed_min_heap_with_position_map] ERROR");
    end
    $finish;
  end

endmodule
